[hdl/timestamp_gap_repair_assert.svh]
// assertion macros for the timestamp gap repair block
`ifndef TIMESTAMP_GAP_REPAIR_ASSERT_SVH
`define TIMESTAMP_GAP_REPAIR_ASSERT_SVH

// same-cycle implication on clk_i, quiet while in reset
`define TGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, quiet while in reset
`define TGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tgr_pkg.sv]
// types and constants for the timestamp gap repair block
`timescale 1ns / 1ps
package tgr_pkg;

  localparam int unsigned KW   = 34;  // width of numerator * 1000
  localparam int unsigned CNTW = 7;   // width of the divider iteration count

  localparam logic [1:0] ACT_PASS    = 2'd0;
  localparam logic [1:0] ACT_INTERP  = 2'd1;
  localparam logic [1:0] ACT_SILENCE = 2'd2;
  localparam logic [1:0] ACT_RESET   = 2'd3;

  localparam logic [7:0] REG_SMALL_LIMIT = 8'd0;
  localparam logic [7:0] REG_LARGE_LIMIT = 8'd1;
  localparam logic [7:0] REG_TB_NUM      = 8'd2;
  localparam logic [7:0] REG_TB_DEN      = 8'd3;

  localparam logic [CNTW-1:0] DIV_FULL_CNT = 7'd64;
  localparam logic [CNTW-1:0] DIV_FRAC_CNT = 7'd58;
  localparam logic [CNTW-1:0] DIV_STEP_CNT = 7'd35;

  typedef struct packed {
    logic               operation;
    logic signed [63:0] frame_time;
    logic signed [63:0] frame_length;
  } in_word_t;

  typedef struct packed {
    logic        [1:0]  action;
    logic signed [63:0] corrected_time;
    logic        [15:0] silence_length_ms;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [CNTW-1:0] count;
  } div_req_t;

endpackage

[hdl/tgr_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tgr_div import tgr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  div_req_t      req_i,
  input  logic [63:0]   dividend_i,
  input  logic [KW-1:0] divisor_i,
  output logic          done_o,
  output logic [63:0]   quotient_o,
  output logic [KW-1:0] remainder_o
);

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [63:0]     dq_q, dq_d;
  logic [KW-1:0]   rem_q, rem_d;
  logic [KW-1:0]   dsr_q, dsr_d;
  logic [KW:0]     trial;
  logic            ge;

  assign trial = {rem_q, dq_q[63]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      cnt_d = req_i.count;
      dq_d  = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNTW'(1));
      dq_d   = {dq_q[62:0], ge};
      rem_d  = ge ? KW'(trial - {1'b0, dsr_q}) : trial[KW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;

endmodule

[hdl/timestamp_gap_repair.sv]
// timestamp gap repair: sequencer, history state and shared divider use
// one frame at a time: a new word is taken only in S_IDLE, after the last frame's word
//   has been loaded into the output register, and S_FIN waits while that register is blocked;
//   the 64-bit radix-2 divider (one bit per cycle) runs the integer and fraction divisions
//   and, for a small gap, the relock step division; a first frame, a zero timebase or a
//   saturated gap skips divisions; a clear gives no word
`timescale 1ns / 1ps
module timestamp_gap_repair import tgr_pkg::*; #(
  parameter int unsigned RELOCK_REPEATS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

`include "timestamp_gap_repair_assert.svh"

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXP   = 4'd1;   // expected time
  localparam logic [3:0] S_GAP   = 4'd2;   // signed gap
  localparam logic [3:0] S_MAG   = 4'd3;   // magnitude, start integer division
  localparam logic [3:0] S_DIV1  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;   // remainder * k
  localparam logic [3:0] S_ADD   = 4'd6;   // add rounding, start fraction division
  localparam logic [3:0] S_DIV2  = 4'd7;
  localparam logic [3:0] S_MUL2  = 4'd8;   // quotient * k
  localparam logic [3:0] S_SUM   = 4'd9;   // sum and saturate
  localparam logic [3:0] S_DEC   = 4'd10;  // classify the gap
  localparam logic [3:0] S_STEP  = 4'd11;  // relock step division
  localparam logic [3:0] S_SMALL = 4'd12;  // repeat tracking and relock
  localparam logic [3:0] S_FIN   = 4'd13;  // hand word to output register

  logic [3:0] state_q, state_d;

  // configuration
  logic [15:0] small_lim_q, large_lim_q;
  logic [23:0] num_q, den_q;

  // history
  logic [63:0] prev_time_q, prev_len_q;
  logic [15:0] psg_q;
  logic [3:0]  rc_q;
  logic        relock_q, started_q;

  // working registers
  logic [63:0]   pts_q, dur_q, exp_q, gap_q;
  logic [15:0]   q_q, ms_q;
  logic [23:0]   r_q;
  logic [57:0]   prod_q;
  logic [34:0]   frac_q, step_q;
  logic [KW-1:0] k_q;
  logic          conv_ok_q;
  out_word_t     res_q;

  logic      out_valid_q;
  out_word_t out_word_q;

  logic in_hs, out_load, dur_pos, pts_pos;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_hs       = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign dur_pos     = (dur_q != '0) && !dur_q[63];
  assign pts_pos     = (in_word_i.frame_length != '0) && !in_word_i.frame_length[63];

  // k = numerator * 1000 by shifts
  logic [KW-1:0] k_d;
  assign k_d = {num_q, 10'b0} - {6'b0, num_q, 4'b0} - {7'b0, num_q, 3'b0};

  // shared multiplier, one product per cycle
  logic [23:0] mul_a;
  logic [57:0] mul_p;
  assign mul_a = (state_q == S_MUL1) ? r_q : {8'b0, q_q};
  assign mul_p = mul_a * k_q;

  // shared divider
  div_req_t      div_req;
  logic [63:0]   div_dvd, mag, q_full;
  logic [KW-1:0] div_dsr, div_rem;
  logic          div_done;
  logic [57:0]   frac_num, ms_sum;
  logic [34:0]   step_num;

  assign mag      = gap_q[63] ? (64'd0 - gap_q) : gap_q;
  assign frac_num = prod_q + {35'b0, den_q[23:1]};
  assign step_num = {10'b0, den_q, 1'b0} + {1'b0, k_q} - 35'd1;
  assign ms_sum   = prod_q + {23'b0, frac_q};

  always_comb begin
    div_req.start = 1'b0;
    div_req.count = DIV_FULL_CNT;
    div_dvd       = mag;
    div_dsr       = {10'b0, den_q};
    unique case (state_q)
      S_MAG: begin
        div_req.start = conv_ok_q;
      end
      S_ADD: begin
        div_req.start = 1'b1;
        div_req.count = DIV_FRAC_CNT;
        div_dvd       = {frac_num, 6'b0};
      end
      S_DEC: begin
        div_req.start = conv_ok_q && !gap_q[63] && (ms_q != '0) && (ms_q < small_lim_q);
        div_req.count = DIV_STEP_CNT;
        div_dvd       = {step_num, 29'b0};
        div_dsr       = k_q;
      end
      S_STEP: begin
        div_dsr = k_q;
      end
      default: begin
      end
    endcase
  end

  tgr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .done_o      (div_done),
    .quotient_o  (q_full),
    .remainder_o (div_rem)
  );

  // repeat tracking for a small gap
  logic        similar, trigger, relock_eff, gap_le;
  logic [3:0]  rc_new;
  logic [63:0] step64;
  assign similar    = (rc_q != '0) && (({1'b0, ms_q} + 17'd2) >= {1'b0, psg_q})
                      && ({1'b0, ms_q} <= ({1'b0, psg_q} + 17'd2));
  assign rc_new     = similar ? (rc_q + 4'd1) : 4'd1;
  assign trigger    = !relock_q && (rc_new >= 4'(RELOCK_REPEATS));
  assign relock_eff = relock_q || trigger;
  assign step64     = {29'b0, step_q};
  assign gap_le     = gap_q <= step64;

  // sequencer and history
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_hs && !in_word_i.operation) begin
                 state_d = started_q ? S_EXP : S_FIN;
               end
      S_EXP:   state_d = S_GAP;
      S_GAP:   state_d = S_MAG;
      S_MAG:   state_d = conv_ok_q ? S_DIV1 : S_DEC;
      S_DIV1:  if (div_done) begin
                 state_d = (q_full[63:16] != '0) ? S_DEC : S_MUL1;
               end
      S_MUL1:  state_d = S_ADD;
      S_ADD:   state_d = S_DIV2;
      S_DIV2:  if (div_done) begin
                 state_d = S_MUL2;
               end
      S_MUL2:  state_d = S_SUM;
      S_SUM:   state_d = S_DEC;
      S_DEC: begin
        priority if (gap_q[63] || ms_q == '0) state_d = S_FIN;
        else if (ms_q < small_lim_q) state_d = conv_ok_q ? S_STEP : S_SMALL;
        else state_d = S_FIN;
      end
      S_STEP:  if (div_done) begin
                 state_d = S_SMALL;
               end
      S_SMALL: state_d = S_FIN;
      S_FIN:   if (out_load) begin
                 state_d = S_IDLE;
               end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      small_lim_q <= 16'd10;
      large_lim_q <= 16'd1000;
      num_q       <= 24'd1;
      den_q       <= 24'd1000;
      prev_time_q <= '0;
      prev_len_q  <= '0;
      psg_q       <= '0;
      rc_q        <= '0;
      relock_q    <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes, expected only while no frame is in flight
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SMALL_LIMIT: small_lim_q <= cfg_data_i[15:0];
          REG_LARGE_LIMIT: large_lim_q <= cfg_data_i[15:0];
          REG_TB_NUM:      num_q       <= cfg_data_i[23:0];
          REG_TB_DEN:      den_q       <= cfg_data_i[23:0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: if (in_hs) begin
          if (in_word_i.operation) begin
            // clear history, keep registers
            prev_time_q <= '0;
            prev_len_q  <= '0;
            psg_q       <= '0;
            rc_q        <= '0;
            relock_q    <= 1'b0;
            started_q   <= 1'b0;
          end else if (!started_q) begin
            // first frame passes and seeds the history
            prev_time_q <= in_word_i.frame_time;
            prev_len_q  <= pts_pos ? in_word_i.frame_length : 64'd1;
            psg_q       <= '0;
            rc_q        <= '0;
            relock_q    <= 1'b0;
            started_q   <= 1'b1;
          end
        end
        S_DEC: begin
          if (gap_q[63] || ms_q == '0 || ms_q >= small_lim_q) begin
            // pass, silence or reset: the frame keeps its own time
            prev_time_q <= pts_q;
            if (dur_pos) prev_len_q <= dur_q;
            psg_q    <= '0;
            rc_q     <= '0;
            relock_q <= 1'b0;
          end
        end
        S_SMALL: begin
          if (relock_eff && gap_le) begin
            // caught up: relock ends, frame passes
            prev_time_q <= pts_q;
            psg_q       <= '0;
            rc_q        <= '0;
            relock_q    <= 1'b0;
          end else begin
            prev_time_q <= relock_eff ? (exp_q + step64) : exp_q;
            if (trigger) begin
              psg_q    <= '0;
              rc_q     <= '0;
              relock_q <= 1'b1;
            end else if (!relock_q) begin
              psg_q <= ms_q;
              rc_q  <= rc_new;
            end
          end
          if (dur_pos) prev_len_q <= dur_q;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_hs) begin
        pts_q <= in_word_i.frame_time;
        dur_q <= in_word_i.frame_length;
        res_q <= '{action: ACT_PASS, corrected_time: in_word_i.frame_time,
                   silence_length_ms: 16'd0};
      end
      S_EXP: begin
        exp_q     <= prev_time_q + prev_len_q;
        k_q       <= k_d;
        conv_ok_q <= (num_q != '0) && (den_q != '0);
      end
      S_GAP: gap_q <= pts_q - exp_q;
      S_MAG: if (!conv_ok_q) ms_q <= '0;
      S_DIV1: if (div_done) begin
        if (q_full[63:16] != '0) begin
          ms_q <= 16'hFFFF;
        end
        q_q <= q_full[15:0];
        r_q <= div_rem[23:0];
      end
      S_MUL1: prod_q <= mul_p;
      S_DIV2: if (div_done) frac_q <= q_full[34:0];
      S_MUL2: prod_q <= mul_p;
      S_SUM:  ms_q <= (ms_sum > 58'd65535) ? 16'hFFFF : ms_sum[15:0];
      S_DEC: begin
        if (!conv_ok_q) step_q <= 35'd1;
        priority if (gap_q[63] || ms_q == '0) begin
          res_q <= '{action: ACT_PASS, corrected_time: pts_q, silence_length_ms: 16'd0};
        end else if (ms_q < small_lim_q) begin
          res_q <= res_q;
        end else if (ms_q < large_lim_q) begin
          res_q <= '{action: ACT_SILENCE, corrected_time: pts_q, silence_length_ms: ms_q};
        end else begin
          res_q <= '{action: ACT_RESET, corrected_time: pts_q, silence_length_ms: 16'd0};
        end
      end
      S_STEP: if (div_done) begin
        step_q <= (q_full[34:0] == '0) ? 35'd1 : q_full[34:0];
      end
      S_SMALL: begin
        if (relock_eff && gap_le) begin
          res_q <= '{action: ACT_PASS, corrected_time: pts_q, silence_length_ms: 16'd0};
        end else begin
          res_q <= '{action: ACT_INTERP,
                     corrected_time: relock_eff ? (exp_q + step64) : exp_q,
                     silence_length_ms: 16'd0};
        end
      end
      default: begin
      end
    endcase
    if (out_load) out_word_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `TGR_ASSERT_IMP(a_div_done_in_div_state,
                  div_done,
                  state_q == S_DIV1 || state_q == S_DIV2 || state_q == S_STEP,
                  "divider finished outside a division state")
  `TGR_ASSERT_IMP(a_relock_no_repeat_history,
                  relock_q,
                  rc_q == '0 && psg_q == '0,
                  "repeat history kept while relocking")
  `TGR_ASSERT_NXT(a_frame_blocks_input,
                  in_hs && !in_word_i.operation,
                  !in_ready_o,
                  "input still ready after a frame was taken")

endmodule

[tb/sv/tb_timestamp_gap_repair.sv]
// testbench for timestamp_gap_repair: directed and random frame streams checked against a scoreboard
`timescale 1ns / 1ps
module tb_timestamp_gap_repair;
  import tgr_pkg::*;

  // input word operations
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam int RELOCK_COUNT = 8;       // matches the default RELOCK_REPEATS of the block
  localparam int GAP_TOL_MS   = 2;       // similar gaps lie within this many ms
  localparam int DRAIN_WAIT   = 300;     // longest frame latency with margin
  localparam int HOLD_CYCLES  = 600;     // long receiver hold-off
  localparam longint CYCLE_LIMIT = 2000000;

  // scoreboard: keeps its own copy of the gap history and the expected words
  class gap_repair_board;
    logic [15:0] small_lim, large_lim;
    logic [63:0] tb_num, tb_den;
    logic [63:0] last_time, last_len, prev_gap_ms;
    logic [3:0]  repeats;
    bit          relocking, running;
    out_word_t   pending[$];
    int          errors;
    int          act_seen[4];
    int          clears, relocks;

    function new();
      small_lim = 16'd10;
      large_lim = 16'd1000;
      tb_num = 64'd1;
      tb_den = 64'd1000;
      errors = 0;
      clears = 0;
      relocks = 0;
      foreach (act_seen[i]) act_seen[i] = 0;
      forget_all();
    endfunction

    function void forget_all();
      last_time = '0;
      last_len = '0;
      prev_gap_ms = '0;
      repeats = '0;
      relocking = 0;
      running = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      case (idx)
        REG_SMALL_LIMIT: small_lim = data[15:0];
        REG_LARGE_LIMIT: large_lim = data[15:0];
        REG_TB_NUM:      tb_num = {40'd0, data[23:0]};
        REG_TB_DEN:      tb_den = {40'd0, data[23:0]};
        default: ;
      endcase
    endfunction

    function bit positive(logic [63:0] v);
      return (v != 0) && !v[63];
    endfunction

    // rounded, saturated ms of a gap magnitude
    function logic [63:0] to_ms(logic [63:0] mag);
      logic [63:0] q, r, k, v;
      if (tb_num == 0 || tb_den == 0) return 0;
      q = mag / tb_den;
      r = mag % tb_den;
      if (q >= 64'd65536) return 64'd65535;
      k = tb_num * 64'd1000;
      v = q * k + (r * k + tb_den / 2) / tb_den;
      return (v > 64'd65535) ? 64'd65535 : v;
    endfunction

    // timebase units per 2 ms slew, rounded up
    function logic [63:0] slew_step();
      logic [63:0] c, t;
      if (tb_num == 0 || tb_den == 0) return 1;
      c = 64'd1000 * tb_num;
      t = (64'd2 * tb_den + c - 1) / c;
      return (t != 0) ? t : 64'd1;
    endfunction

    function logic [63:0] expected_time();
      return last_time + last_len;
    endfunction

    function void push(logic [1:0] act, logic [63:0] t, logic [15:0] sil);
      out_word_t w;
      w.action = act;
      w.corrected_time = t;
      w.silence_length_ms = sil;
      pending.push_back(w);
      act_seen[act]++;
    endfunction

    // accepted input word: advance the history and queue its result, if any
    function void note_frame(in_word_t w);
      logic [63:0] pts, dur, expd, gap, mag, ms, step, fixed;
      logic [1:0] act;
      bit back, similar;
      pts = w.frame_time;
      dur = w.frame_length;
      if (w.operation == OP_CLEAR) begin
        forget_all();
        clears++;
        return;
      end
      if (!running) begin
        last_time = pts;
        last_len = positive(dur) ? dur : 64'd1;
        prev_gap_ms = 0;
        repeats = 0;
        relocking = 0;
        running = 1;
        push(ACT_PASS, pts, 16'd0);
        return;
      end
      expd = expected_time();
      gap = pts - expd;
      back = gap[63];
      mag = back ? -gap : gap;
      ms = to_ms(mag);
      if (back || ms < 1) begin
        last_time = pts;
        if (positive(dur)) last_len = dur;
        prev_gap_ms = 0;
        repeats = 0;
        relocking = 0;
        push(ACT_PASS, pts, 16'd0);
        return;
      end
      if (ms < small_lim) begin
        step = slew_step();
        if (!relocking) begin
          similar = (repeats != 0) && (ms + GAP_TOL_MS >= prev_gap_ms) &&
                    (ms <= prev_gap_ms + GAP_TOL_MS);
          repeats = similar ? repeats + 4'd1 : 4'd1;
          prev_gap_ms = ms;
          if (repeats >= RELOCK_COUNT) begin
            relocking = 1;
            relocks++;
            prev_gap_ms = 0;
            repeats = 0;
          end
        end
        if (relocking) begin
          // close enough to the slewed time: relock is done
          if (gap <= step) begin
            last_time = pts;
            if (positive(dur)) last_len = dur;
            prev_gap_ms = 0;
            repeats = 0;
            relocking = 0;
            push(ACT_PASS, pts, 16'd0);
            return;
          end
          fixed = expd + step;
        end else begin
          fixed = expd;
        end
        act = ACT_INTERP;
        ms = 0;
      end else begin
        prev_gap_ms = 0;
        repeats = 0;
        relocking = 0;
        fixed = pts;
        if (ms < large_lim) begin
          act = ACT_SILENCE;
        end else begin
          act = ACT_RESET;
          ms = 0;
        end
      end
      last_time = fixed;
      if (positive(dur)) last_len = dur;
      push(act, fixed, ms[15:0]);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected output word action=%0d time=%0d", got.action, got.corrected_time);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.action !== exp_w.action) begin
        $error("action: expected %0d, got %0d", exp_w.action, got.action);
        errors++;
      end
      if (got.corrected_time !== exp_w.corrected_time) begin
        $error("corrected_time: expected %0d, got %0d",
               exp_w.corrected_time, got.corrected_time);
        errors++;
      end
      if (got.silence_length_ms !== exp_w.silence_length_ms) begin
        $error("silence_length_ms: expected %0d, got %0d",
               exp_w.silence_length_ms, got.silence_length_ms);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  gap_repair_board board;
  longint cycles;
  int     frames_sent;
  bit     hold_req;
  int     burst_left;
  int     run_left;
  int     run_ms;

  timestamp_gap_repair uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: stall pattern in segments, plus a long hold-off on request
  initial begin
    int seg, seg_mode, stall;
    out_ready_i = 1'b0;
    seg = 0;
    seg_mode = 0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) board.check_word(out_word_o);
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        if (out_valid_o && out_ready_i) board.check_word(out_word_o);
      end
      if (seg == 0) begin
        seg = $urandom_range(20, 400);
        seg_mode = $urandom_range(0, 2);
      end
      seg--;
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        case (seg_mode)
          0: out_ready_i <= 1'b1;                       // never stall
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 3) == 0) stall = $urandom_range(1, 12);
            out_ready_i <= (stall == 0);
          end
        endcase
      end
    end
  end

  // sender: one word, with random bursts and gaps around it
  task automatic send_word(in_word_t w);
    int gap_cycles;
    if (burst_left == 0) begin
      gap_cycles = $urandom_range(0, 25);
      if (gap_cycles > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_cycles) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_frame(w);
    frames_sent++;
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  task automatic send_frame(logic [63:0] t, logic [63:0] len);
    in_word_t w;
    w.operation = OP_FRAME;
    w.frame_time = t;
    w.frame_length = len;
    send_word(w);
  endtask

  task automatic send_clear();
    in_word_t w;
    w.operation = OP_CLEAR;
    w.frame_time = {$urandom, $urandom};
    w.frame_length = {$urandom, $urandom};
    send_word(w);
  endtask

  // timestamp that lands a given number of ms after the expected one
  function automatic logic [63:0] time_at(int ms);
    logic [63:0] units;
    if (board.tb_num == 0 || board.tb_den == 0)
      units = 64'(ms);
    else
      units = (64'(ms) * board.tb_den + 64'd500 * board.tb_num) / (64'd1000 * board.tb_num);
    return board.expected_time() + units;
  endfunction

  // typical frame duration: 10 to 40 ms, sometimes zero or negative
  function automatic logic [63:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 64'd0;
    if (r == 1) return -64'($urandom_range(1, 100000));
    if (board.tb_num == 0 || board.tb_den == 0) return 64'($urandom_range(1, 5000));
    return 64'd1 + (64'($urandom_range(10, 40)) * board.tb_den) / (64'd1000 * board.tb_num);
  endfunction

  // all registers written only with nothing left in flight
  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  task automatic drain();
    idle_input();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_timing(int sm, int lg, int num, int den);
    drain();
    write_reg(REG_SMALL_LIMIT, sm);
    write_reg(REG_LARGE_LIMIT, lg);
    write_reg(REG_TB_NUM, num);
    write_reg(REG_TB_DEN, den);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic directed_frames();
    send_clear();
    send_frame(64'h7fff_ffff_ffff_ffff, 64'd0);     // first frame, duration defaults to 1
    send_frame(64'h8000_0000_0000_0000, 64'd20);    // wrapped expected time
    send_frame(time_at(0), 64'h8000_0000_0000_0000); // exact, most negative length
    send_frame(board.expected_time() - 64'd5, 64'h7fff_ffff_ffff_ffff);
    send_clear();
    send_frame(64'd1000, 64'd20);
    send_frame(time_at(3), 64'd20);                 // small gap
    send_frame(time_at(50), -64'd1);                // medium gap
    send_frame(time_at(2000), 64'd20);              // large gap
    send_frame(board.expected_time() - 64'd1, 64'd20); // backward
    for (int i = 0; i < 9; i++)                       // similar gaps start the relock
      send_frame(time_at(4 + (i % 3) - 1), 64'd20);
    send_frame(time_at(1), 64'd20);                 // within the slew step, relock ends
    send_frame(time_at(9), 64'd20);
    send_frame(time_at(10), 64'd20);
    send_frame(time_at(999), 64'd20);
    send_frame(time_at(1000), 64'd20);
  endtask

  task automatic random_frames(int count);
    int r, ms, sm, lg;
    in_word_t w;
    for (int n = 0; n < count; n++) begin
      sm = board.small_lim;
      lg = board.large_lim;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_clear();
      end else if (r < 9) begin
        // noise: every bit of the fields in play
        w.operation = OP_FRAME;
        w.frame_time = {$urandom, $urandom};
        w.frame_length = {$urandom, $urandom};
        send_word(w);
      end else if (r < 14) begin
        send_frame(board.expected_time() - 64'($urandom_range(1, 100000)), pick_length());
      end else if (r < 55) begin
        // small gaps, often in similar runs that lead into a relock
        if (run_left == 0 && $urandom_range(0, 1)) begin
          run_left = $urandom_range(6, 14);
          run_ms = $urandom_range(1, (sm > 2) ? sm - 1 : 1);
        end
        if (run_left > 0) begin
          run_left--;
          ms = run_ms + $urandom_range(0, 2) - 1;
          if (ms < 1) ms = 1;
        end else begin
          ms = $urandom_range(1, (sm > 2) ? sm - 1 : 1);
        end
        send_frame(time_at(ms), pick_length());
      end else if (r < 70) begin
        send_frame(time_at(0), pick_length());
      end else if (r < 87) begin
        ms = $urandom_range(sm, (lg > sm) ? lg : sm);
        send_frame(time_at(ms), pick_length());
      end else if (r < 97) begin
        send_frame(time_at($urandom_range(lg, lg + 3000)), pick_length());
      end else begin
        send_frame(board.expected_time() + {1'b0, 31'($urandom), $urandom},
                   pick_length());
      end
    end
  endtask

  initial begin
    board = new();
    frames_sent = 0;
    hold_req = 0;
    burst_left = 0;
    run_left = 0;
    run_ms = 1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_frames();
    random_frames(120);
    hold_req = 1;                       // receiver backs off, sender keeps pushing
    random_frames(80);

    set_timing(10, 1000, 1, 90000);     // 90 kHz clock
    random_frames(200);
    set_timing(25, 300, 1, 48000);
    random_frames(200);
    set_timing(0, 0, 1, 1000);          // nothing is small, every forward gap of 1 ms or more resets
    random_frames(100);
    set_timing(65535, 65535, 24'hff_ffff, 24'hff_ffff);
    random_frames(150);
    set_timing(12, 500, 0, 1000);       // zero numerator
    random_frames(100);
    set_timing(12, 500, 1, 0);          // zero denominator
    random_frames(100);
    set_timing(6, 200, 3, 1);           // coarse ticks, step of one unit
    random_frames(150);
    set_timing(40, 2000, 1, 16777215);
    random_frames(200);

    drain();
    $display("covered %0d input words (%0d clears), %0d relocks, timebase and limit extremes",
             frames_sent, board.clears, board.relocks);
    $display("results: pass %0d, interpolate %0d, silence %0d, reset %0d",
             board.act_seen[ACT_PASS], board.act_seen[ACT_INTERP],
             board.act_seen[ACT_SILENCE], board.act_seen[ACT_RESET]);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/tgr_pkg.sv
hdl/tgr_div.sv
hdl/timestamp_gap_repair.sv
tb/sv/tb_timestamp_gap_repair.sv
